>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, constants and round functions for the SHA-256 byte-stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       carries_byte;
		logic       end_of_message;
	} sha256_in_t;

	typedef struct packed {
		logic [63:0] digest_bytes_0_7;
		logic [63:0] digest_bytes_8_15;
		logic [63:0] digest_bytes_16_23;
		logic [63:0] digest_bytes_24_31;
	} sha256_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_DONE
	} sha256_state_t;

	// Padding phase: the 0x80 byte, zero fill, or the length field.
	typedef enum logic [1:0] {
		PH_PAD80,
		PH_ZERO,
		PH_LEN
	} sha256_pad_phase_t;

	// Start request and done flag between the control and the round engine.
	typedef struct packed {
		logic start;
		logic done;
	} sha256_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

endpackage

>>> rtl/core/sha256_rounds.sv
// ----------------------------------------------------------------------------
// sha256_rounds
// Compression engine: message schedule kept in a 16-word sliding window,
// 64 rounds at one per cycle, then folds into the chaining words.
// ----------------------------------------------------------------------------
module sha256_rounds import sha256_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [511:0]       block,
	input  logic [255:0]       chain_in,
	output logic [255:0]       chain_out,
	output logic               done
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [6:0]  rnd_q;
	logic        busy_q;
	logic [31:0] w_new, t1, t2, wcur;

	assign wcur  = w_q[0];
	assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[rnd_q[5:0]] + wcur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= chain_in[255 - 32*i -: 32];
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++)
			chain_out[255 - 32*i -: 32] = chain_in[255 - 32*i -: 32] + v_q[i];
	end

endmodule

>>> rtl/core/sha256_byte_stream_hasher_unit.sv
// A byte that does not fill a block is only written to the buffer; a full block
// goes through the load sweep, the 64 rounds and the fold.
// End of message: padding writes 1 byte per cycle to the block end, then one or two
// compressions follow; the digest is registered and valid in the cycle after the final fold.
// Intake: bytes are taken only in idle, not while a block is padded, loaded or compressed.
// Reset: chaining words to the initial hash values, fill and byte count to zero.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// Byte-serial SHA-256: bytes land in a 64-entry buffer memory, full blocks
// go to the round engine, and the end mark pads and emits the digest.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sha256_in_t  in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output sha256_out_t out_data
);

	// block buffer memory, one byte per entry, synchronous read
	logic [7:0]   buf_mem [64];
	logic [7:0]   rd_data_s1;
	logic [5:0]   rd_addr;
	logic         wr_en;
	logic [5:0]   wr_addr;
	logic [7:0]   wr_data;

	sha256_state_t     state_q, state_d;
	sha256_pad_phase_t phase_q;
	logic [5:0]   fill_q;
	logic [63:0]  total_q;
	logic [63:0]  bits_q;
	logic [2:0]   len_idx_q;
	logic         final_q;      // compressing the last block of a message
	logic         pending_pad_q;  // end mark seen, padding still in progress
	logic [6:0]   ld_cnt_q;     // load sweep counter, includes read latency
	logic [511:0] block_q;
	logic [255:0] chain_q;
	logic [255:0] chain_new;
	logic         eng_done;
	logic         eng_start;
	logic         take;

	assign take     = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (wr_en) buf_mem[wr_addr] <= wr_data;
		rd_data_s1 <= buf_mem[rd_addr];
	end

	assign rd_addr = ld_cnt_q[5:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (in_data.carries_byte && fill_q == 6'd63) state_d = ST_LOAD;
					else if (in_data.end_of_message) state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (fill_q == 6'd63) state_d = ST_LOAD;
			end
			ST_LOAD:  if (ld_cnt_q == 7'd65) state_d = ST_ROUND;
			ST_ROUND: if (eng_done) state_d = ST_FOLD;
			ST_FOLD: begin
				// final fold waits until the previous digest has left
				if (final_q) state_d = out_valid ? ST_FOLD : ST_DONE;
				else if (phase_q != PH_PAD80 || pending_pad_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// byte written during intake or padding
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q;
		wr_data = in_data.data_byte;
		if (state_q == ST_IDLE && take && in_data.carries_byte) begin
			wr_en = 1'b1;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			unique case (phase_q)
				PH_PAD80: wr_data = PAD_BYTE;
				PH_ZERO:  wr_data = 8'h00;
				PH_LEN:   wr_data = bits_q[63 - 8*len_idx_q -: 8];
				default:  wr_data = 8'h00;
			endcase
		end
	end

	// last buffer byte lands in block_q at count 64, engine start is raised at count 65
	assign eng_start = (state_q == ST_LOAD) && (ld_cnt_q == 7'd65);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_PAD80;
			fill_q        <= '0;
			total_q       <= '0;
			len_idx_q     <= '0;
			final_q       <= 1'b0;
			pending_pad_q <= 1'b0;
			ld_cnt_q      <= '0;
			out_valid     <= 1'b0;
			for (int i = 0; i < 8; i++) chain_q[255 - 32*i -: 32] <= INIT_WORDS[i];
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (state_q != ST_LOAD) ld_cnt_q <= '0;
			else ld_cnt_q <= ld_cnt_q + 7'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (in_data.carries_byte) begin
							fill_q  <= fill_q + 6'd1;
							total_q <= total_q + 64'd1;
						end
						if (in_data.end_of_message) begin
							pending_pad_q <= 1'b1;
							phase_q       <= PH_PAD80;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					unique case (phase_q)
						PH_PAD80: begin
							bits_q <= {total_q[60:0], 3'b000};
							phase_q <= (fill_q == LEN_POS - 6'd1) ? PH_LEN : PH_ZERO;
							len_idx_q <= '0;
						end
						PH_ZERO: if (fill_q == LEN_POS - 6'd1) phase_q <= PH_LEN;
						PH_LEN: begin
							len_idx_q <= len_idx_q + 3'd1;
							if (fill_q == 6'd63) final_q <= 1'b1;
						end
						default: ;
					endcase
				end
				ST_LOAD: begin
					if (ld_cnt_q != 7'd0 && ld_cnt_q <= 7'd64)
						block_q[511 - 8*(ld_cnt_q - 7'd1) -: 8] <= rd_data_s1;
					if (ld_cnt_q == 7'd0 && !pending_pad_q) fill_q <= '0;
				end
				ST_FOLD: begin
					if (!(final_q && out_valid)) begin
						chain_q <= chain_new;
						if (final_q) begin
							out_data <= chain_new;
							out_valid <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					for (int i = 0; i < 8; i++) chain_q[255 - 32*i -: 32] <= INIT_WORDS[i];
					fill_q        <= '0;
					total_q       <= '0;
					final_q       <= 1'b0;
					pending_pad_q <= 1'b0;
					phase_q       <= PH_PAD80;
				end
				default: ;
			endcase
		end
	end

	sha256_rounds u_rounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (eng_start),
		.block     (block_q),
		.chain_in  (chain_q),
		.chain_out (chain_new),
		.done      (eng_done)
	);

	`ASSERT_IMPL(a_no_take_busy, clk, arst_n, state_q != ST_IDLE, !take, "item taken while busy")
	`ASSERT_NEXT(a_done_fold, clk, arst_n, eng_done, state_q == ST_FOLD, "round done outside fold")
	`ASSERT_IMPL(a_out_final, clk, arst_n, $rose(out_valid), $past(final_q), "digest not final")

endmodule
